// File: src/stable_sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Stable sorted priority queue: assertion macros
// Shared property wrappers for the concurrent checks of the queue.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SSPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sspq check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SSPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sspq check failed");

`endif

// File: src/sspq_pkg.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue package
// Default sizes, result status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sspq_pkg;

	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int TAG_BITS_DEF      = 16;
	localparam int PRIORITY_BITS_DEF = 3;

	typedef logic [1:0] status_t;

	localparam status_t ST_INSERTED = 2'd0;
	localparam status_t ST_REMOVED  = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;
	localparam status_t ST_FULL     = 2'd3;

	// Action codes of a request
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;      // capture the request operands
		logic ins;       // insert the held item
		logic rem;       // pop the front item
		logic rej_full;  // report insert on full
		logic rej_empty; // report remove on empty
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic op_remove; // held request is a remove
		logic full;      // every slot is in use
		logic empty;     // no slot is in use
	} dp_sts_t;

endpackage

// File: src/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue
// Bounded queue kept in priority order; equal priorities leave in arrival
// order.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   carries action (insert or remove), priority_req and item_tag.
//   Every request gives exactly one result, shown for one cycle with valid
//   high: status, out_tag, out_priority and item_count after the operation.
//   Timing: the accepting edge captures the operands and enters the exec
//   state; the operation then registers valid and the result fields.
//   busy is high for the one cycle in which the entry row compares and
//   shifts all slots at once, and no request is taken while it is high.
//   A new request may be taken in the same cycle its predecessor's result
//   is shown.
//   Reset empties the queue at once; no clearing pass is needed since only
//   slots below the count are ever read.
//   The receiver cannot stall: a result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
`include "stable_sorted_priority_queue_defines.svh"

module stable_sorted_priority_queue #(
	parameter int QUEUE_DEPTH   = sspq_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS      = sspq_pkg::TAG_BITS_DEF,
	parameter int PRIORITY_BITS = sspq_pkg::PRIORITY_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic [PRIORITY_BITS-1:0]         priority_req,
	input  logic [TAG_BITS-1:0]              item_tag,
	output logic                             valid,
	output sspq_pkg::status_t                status,
	output logic [TAG_BITS-1:0]              out_tag,
	output logic [PRIORITY_BITS-1:0]         out_priority,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] item_count
);
	import sspq_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// Sequence requests
	sspq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Store and reorder entries
	sspq_datapath #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.TAG_BITS      (TAG_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (action),
		.priority_req (priority_req),
		.item_tag     (item_tag),
		.valid        (valid),
		.status       (status),
		.out_tag      (out_tag),
		.out_priority (out_priority),
		.item_count   (item_count)
	);

	// Check result timing and special-case fields
	`SSPQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !valid)
	`SSPQ_ASSERT_NEXT(a_busy_result, clk, arst_n, busy, valid && !busy)
	`SSPQ_ASSERT_SAME(a_full_count, clk, arst_n, valid && status == ST_FULL,
		item_count == QUEUE_DEPTH)
	`SSPQ_ASSERT_SAME(a_empty_zero, clk, arst_n, valid && status == ST_EMPTY,
		item_count == 0 && out_tag == 0)

endmodule

// File: src/sspq_datapath.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue datapath
// Row of sorted entry cells with per-cell compare and shift, operand and
// result registers, and the item counter.
// ----------------------------------------------------------------------------
module sspq_datapath #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int TAG_BITS      = 16,
	parameter int PRIORITY_BITS = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sspq_pkg::ctl_cmd_t                 cmd,
	output sspq_pkg::dp_sts_t                  sts,
	input  logic                               action,
	input  logic [PRIORITY_BITS-1:0]           priority_req,
	input  logic [TAG_BITS-1:0]                item_tag,
	output logic                               valid,
	output sspq_pkg::status_t                  status,
	output logic [TAG_BITS-1:0]                out_tag,
	output logic [PRIORITY_BITS-1:0]           out_priority,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   item_count
);
	import sspq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Request operands
	logic                     op_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic [TAG_BITS-1:0]      tag_q;

	// Sorted entry row, slot 0 is the front
	logic [TAG_BITS-1:0]      cell_tag_q [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0] cell_pri_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   ge;
	logic [CNT_W-1:0]         count_q;

	// Result registers
	logic                     valid_q;
	status_t                  status_q;
	logic [TAG_BITS-1:0]      out_tag_q;
	logic [PRIORITY_BITS-1:0] out_pri_q;
	logic [CNT_W-1:0]         out_cnt_q;

	// Capture operands of an accepted request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= action;
			pri_q <= priority_req;
			tag_q <= item_tag;
		end
	end

	// Report operation kind and fill state
	assign sts.op_remove = (op_q == ACT_REMOVE);
	assign sts.full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign sts.empty     = (count_q == '0);

	// Flag each valid slot that the new item must stay behind
	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			assign ge[i] = (CNT_W'(i) < count_q) && (cell_pri_q[i] >= pri_q);

			if (i == 0) begin : g_front
				// Front slot: take new item or next slot
				always_ff @(posedge clk) begin
					if (cmd.ins && !ge[0]) begin
						cell_tag_q[0] <= tag_q;
						cell_pri_q[0] <= pri_q;
					end else if (cmd.rem && QUEUE_DEPTH > 1) begin
						cell_tag_q[0] <= cell_tag_q[(QUEUE_DEPTH > 1) ? 1 : 0];
						cell_pri_q[0] <= cell_pri_q[(QUEUE_DEPTH > 1) ? 1 : 0];
					end
				end
			end else begin : g_rest
				// Other slots: hold, take new item, shift back or shift forward
				always_ff @(posedge clk) begin
					if (cmd.ins && !ge[i]) begin
						if (ge[i-1]) begin
							cell_tag_q[i] <= tag_q;
							cell_pri_q[i] <= pri_q;
						end else begin
							cell_tag_q[i] <= cell_tag_q[i-1];
							cell_pri_q[i] <= cell_pri_q[i-1];
						end
					end else if (cmd.rem && i < QUEUE_DEPTH - 1) begin
						cell_tag_q[i] <= cell_tag_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
						cell_pri_q[i] <= cell_pri_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
					end
				end
			end
		end
	endgenerate

	// Advance the item count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Strobe the result one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.ins | cmd.rem | cmd.rej_full | cmd.rej_empty;
		end
	end

	// Build the result fields
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			status_q  <= ST_INSERTED;
			out_tag_q <= '0;
			out_pri_q <= '0;
			out_cnt_q <= count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			status_q  <= ST_REMOVED;
			out_tag_q <= cell_tag_q[0];
			out_pri_q <= cell_pri_q[0];
			out_cnt_q <= count_q - CNT_W'(1);
		end else if (cmd.rej_full) begin
			status_q  <= ST_FULL;
			out_tag_q <= '0;
			out_pri_q <= '0;
			out_cnt_q <= count_q;
		end else if (cmd.rej_empty) begin
			status_q  <= ST_EMPTY;
			out_tag_q <= '0;
			out_pri_q <= '0;
			out_cnt_q <= count_q;
		end
	end

	assign valid        = valid_q;
	assign status       = status_q;
	assign out_tag      = out_tag_q;
	assign out_priority = out_pri_q;
	assign item_count   = out_cnt_q;

endmodule

// File: src/sspq_ctrl.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue controller
// Accepts one request at a time and picks the datapath operation for it.
// ----------------------------------------------------------------------------
module sspq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sspq_pkg::dp_sts_t  sts,
	output sspq_pkg::ctl_cmd_t cmd
);
	import sspq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	// Sequence: capture in idle, operate in exec
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.op_remove) begin
					cmd.rem       = !sts.empty;
					cmd.rej_empty = sts.empty;
				end else begin
					cmd.ins      = !sts.full;
					cmd.rej_full = sts.full;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == S_EXEC);

endmodule

// File: dv/stable_sorted_priority_queue_test.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue testbench
// Drives insert and remove requests through the start/busy handshake and
// checks every result strobe against a sorted-list predictor of the queue.
// Equal priorities must leave in arrival order. Full and empty rejects are
// reached by bursts that lean toward inserts or toward removes.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_test;

	import sspq_pkg::*;

	localparam int DEPTH      = QUEUE_DEPTH_DEF;
	localparam int TAG_W      = TAG_BITS_DEF;
	localparam int PRI_W      = PRIORITY_BITS_DEF;
	localparam int COUNT_W    = $clog2(DEPTH + 1);
	localparam int RAND_ITEMS = 1880;
	localparam int CYCLE_CAP  = 200000;
	localparam int QUIET_LO   = 700;
	localparam int QUIET_HI   = 1100;

	typedef struct {
		logic             act;
		logic [PRI_W-1:0] pri;
		logic [TAG_W-1:0] tag;
	} request_t;

	typedef struct {
		status_t            status;
		logic [TAG_W-1:0]   tag;
		logic [PRI_W-1:0]   pri;
		logic [COUNT_W-1:0] count;
	} outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               action = ACT_INSERT;
	logic [PRI_W-1:0]   priority_req = '0;
	logic [TAG_W-1:0]   item_tag = '0;
	logic               busy;
	logic               valid;
	status_t            status;
	logic [TAG_W-1:0]   out_tag;
	logic [PRI_W-1:0]   out_priority;
	logic [COUNT_W-1:0] item_count;

	// Predictor state: slot 0 is the front of the queue
	logic [TAG_W-1:0] slot_tag [DEPTH];
	logic [PRI_W-1:0] slot_pri [DEPTH];
	int               held_items = 0;

	request_t pending_requests[$];
	outcome_t awaited_results[$];
	outcome_t issued_outcome;
	outcome_t seen;
	outcome_t want;
	int       accepted_count = 0;
	int       fail_count = 0;
	int       cycle_count = 0;
	bit       idle_now;

	stable_sorted_priority_queue i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.priority_req (priority_req),
		.item_tag     (item_tag),
		.valid        (valid),
		.status       (status),
		.out_tag      (out_tag),
		.out_priority (out_priority),
		.item_count   (item_count)
	);

	always #6 clk = ~clk;

	// Apply one request to the sorted list and produce its result
	task automatic apply_to_sorted_list(input request_t rq, output outcome_t res);
		int pos;
		res.status = ST_INSERTED;
		res.tag = '0;
		res.pri = '0;
		if (rq.act == ACT_INSERT) begin
			if (held_items >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				// go behind every entry of equal or higher priority
				pos = 0;
				while (pos < held_items && slot_pri[pos] >= rq.pri)
					pos++;
				for (int i = held_items; i > pos; i--) begin
					slot_tag[i] = slot_tag[i-1];
					slot_pri[i] = slot_pri[i-1];
				end
				slot_tag[pos] = rq.tag;
				slot_pri[pos] = rq.pri;
				held_items++;
			end
		end else if (held_items == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.status = ST_REMOVED;
			res.tag = slot_tag[0];
			res.pri = slot_pri[0];
			for (int i = 0; i + 1 < held_items; i++) begin
				slot_tag[i] = slot_tag[i+1];
				slot_pri[i] = slot_pri[i+1];
			end
			held_items--;
		end
		res.count = COUNT_W'(held_items);
	endtask

	task automatic queue_request(input logic act, input int pri, input int tag);
		request_t rq;
		rq.act = act;
		rq.pri = PRI_W'(pri);
		rq.tag = TAG_W'(tag);
		pending_requests.push_back(rq);
	endtask

	// Driver: predict each accepted request, then present the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				apply_to_sorted_list('{action, priority_req, item_tag}, issued_outcome);
				awaited_results.push_back(issued_outcome);
				accepted_count++;
			end
			idle_now = ($urandom_range(99) < 16) &&
				!(accepted_count >= QUIET_LO && accepted_count < QUIET_HI);
			if (start && busy) begin
				// hold the request until the block takes it
			end else if (pending_requests.size() != 0 && !idle_now) begin
				action       <= pending_requests[0].act;
				priority_req <= pending_requests[0].pri;
				item_tag     <= pending_requests[0].tag;
				void'(pending_requests.pop_front());
				start        <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare every strobed result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && valid) begin
			seen = '{status, out_tag, out_priority, item_count};
			if (awaited_results.size() == 0) begin
				$error("result with no request outstanding: status %0d", seen.status);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (seen.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, seen.status);
					fail_count++;
				end
				if (seen.tag !== want.tag) begin
					$error("out_tag: expected %0h, actual %0h", want.tag, seen.tag);
					fail_count++;
				end
				if (seen.pri !== want.pri) begin
					$error("out_priority: expected %0d, actual %0d", want.pri, seen.pri);
					fail_count++;
				end
				if (seen.count !== want.count) begin
					$error("item_count: expected %0d, actual %0d", want.count, seen.count);
					fail_count++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int mode;
		int burst;
		int made;
		int pri;

		// directed: empty remove, priority extremes, ties in arrival order
		queue_request(ACT_REMOVE, 7, 16'hffff);
		queue_request(ACT_INSERT, 0, 16'h0000);
		queue_request(ACT_INSERT, 7, 16'hffff);
		queue_request(ACT_INSERT, 3, 16'h1111);
		queue_request(ACT_INSERT, 3, 16'h2222);
		queue_request(ACT_INSERT, 7, 16'h3333);
		queue_request(ACT_INSERT, 0, 16'h4444);
		queue_request(ACT_INSERT, 3, 16'h5555);
		for (int i = 0; i < 8; i++)
			queue_request(ACT_REMOVE, 0, 16'hffff);
		queue_request(ACT_INSERT, 5, 16'haaaa);
		queue_request(ACT_REMOVE, 0, 0);
		queue_request(ACT_REMOVE, 0, 0);

		// random bursts leaning toward fill, drain or a mix
		made = 0;
		while (made < RAND_ITEMS) begin
			mode = $urandom_range(2);
			burst = $urandom_range(20, 60);
			for (int i = 0; i < burst; i++) begin
				if ($urandom_range(3) == 0)
					pri = $urandom_range(1);
				else
					pri = $urandom_range((1 << PRI_W) - 1);
				case (mode)
					0: queue_request(($urandom_range(99) < 80) ? ACT_INSERT : ACT_REMOVE,
						pri, $urandom);
					1: queue_request(($urandom_range(99) < 80) ? ACT_REMOVE : ACT_INSERT,
						pri, $urandom);
					default: queue_request($urandom_range(1) ? ACT_REMOVE : ACT_INSERT,
						pri, $urandom);
				endcase
			end
			made += burst;
		end

		// release reset on a clock edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// drain stimulus, then the outstanding results
		while (pending_requests.size() != 0 || start)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
